// ===== hw/rtl/cbp_pkg.sv =====
// Package for the convolutional branch predictor.
// Holds shared field widths, register indexes, the controller state type and
// the command/status structs. No dependencies.
package cbp_pkg;

  // Fixed field widths
  localparam int ADDR_W     = 64;
  localparam int OUT_W      = 22;
  localparam int THR_W      = 12;
  localparam int SPD_W      = 5;
  localparam int TC_W       = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;
  localparam int N_TAPS     = 4;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_INIT_THR    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ADAPT_SPEED = 1'b1;

  // Register reset values and limits
  localparam logic [THR_W-1:0] THR_RST = 12'd69;
  localparam logic [SPD_W-1:0] SPD_RST = 5'd18;
  localparam logic [THR_W-1:0] THR_MAX = 12'd4095;

  // Request codes
  localparam logic REQ_PREDICT = 1'b0;
  localparam logic REQ_RESOLVE = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_P_RD,
    S_P_LOAD,
    S_P_MAC,
    S_P_FIN,
    S_R_RD,
    S_R_CMP,
    S_SH_RD,
    S_SH_WR,
    S_R_IDX,
    S_T_LOAD,
    S_T_STEP,
    S_T_FIN
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic clr_step;
    logic accept;
    logic p_read;
    logic p_load;
    logic mac_step;
    logic p_fin;
    logic r_cmp;
    logic sh_read;
    logic sh_write;
    logic r_idx;
    logic r_none;
    logic t_load;
    logic t_step;
    logic t_fin;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic step_last;
    logic k_end;
    logic k_last;
    logic match;
    logic train;
  } sts_t;

endpackage

// ===== hw/rtl/cbp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/cbp_ctrl.sv =====
// Controller state machine of the convolutional branch predictor.
// Depends on cbp_pkg for the state type and the command/status structs.
module cbp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           req_type,
  input  cbp_pkg::sts_t  sts,
  output cbp_pkg::cmd_t  cmd,
  output logic           busy
);

  cbp_pkg::state_t state_r, state_nxt;

  // State register; reset starts the table clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cbp_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cbp_pkg::S_CLEAR:  if (sts.clr_last) state_nxt = cbp_pkg::S_IDLE;
      cbp_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = (req_type == cbp_pkg::REQ_RESOLVE) ? cbp_pkg::S_R_RD : cbp_pkg::S_P_RD;
        end
      end
      cbp_pkg::S_P_RD:   state_nxt = cbp_pkg::S_P_LOAD;
      cbp_pkg::S_P_LOAD: state_nxt = cbp_pkg::S_P_MAC;
      cbp_pkg::S_P_MAC:  if (sts.step_last) state_nxt = cbp_pkg::S_P_FIN;
      cbp_pkg::S_P_FIN:  state_nxt = cbp_pkg::S_IDLE;
      cbp_pkg::S_R_RD:   state_nxt = sts.k_end ? cbp_pkg::S_IDLE : cbp_pkg::S_R_CMP;
      cbp_pkg::S_R_CMP:  state_nxt = sts.match ? cbp_pkg::S_SH_RD : cbp_pkg::S_R_RD;
      cbp_pkg::S_SH_RD:  state_nxt = sts.k_last ? cbp_pkg::S_R_IDX : cbp_pkg::S_SH_WR;
      cbp_pkg::S_SH_WR:  state_nxt = cbp_pkg::S_SH_RD;
      cbp_pkg::S_R_IDX:  state_nxt = sts.train ? cbp_pkg::S_T_LOAD : cbp_pkg::S_IDLE;
      cbp_pkg::S_T_LOAD: state_nxt = cbp_pkg::S_T_STEP;
      cbp_pkg::S_T_STEP: if (sts.step_last) state_nxt = cbp_pkg::S_T_FIN;
      cbp_pkg::S_T_FIN:  state_nxt = cbp_pkg::S_IDLE;
      default:           state_nxt = cbp_pkg::S_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd  = '0;
    busy = (state_r != cbp_pkg::S_IDLE);
    unique case (state_r)
      cbp_pkg::S_CLEAR:  cmd.clr_step = 1'b1;
      cbp_pkg::S_IDLE:   cmd.accept   = start;
      cbp_pkg::S_P_RD:   cmd.p_read   = 1'b1;
      cbp_pkg::S_P_LOAD: cmd.p_load   = 1'b1;
      cbp_pkg::S_P_MAC:  cmd.mac_step = 1'b1;
      cbp_pkg::S_P_FIN:  cmd.p_fin    = 1'b1;
      cbp_pkg::S_R_RD:   cmd.r_none   = sts.k_end;
      cbp_pkg::S_R_CMP:  cmd.r_cmp    = 1'b1;
      cbp_pkg::S_SH_RD:  cmd.sh_read  = !sts.k_last;
      cbp_pkg::S_SH_WR:  cmd.sh_write = 1'b1;
      cbp_pkg::S_R_IDX:  cmd.r_idx    = 1'b1;
      cbp_pkg::S_T_LOAD: cmd.t_load   = 1'b1;
      cbp_pkg::S_T_STEP: cmd.t_step   = 1'b1;
      cbp_pkg::S_T_FIN:  cmd.t_fin    = 1'b1;
      default:           cmd          = '0;
    endcase
  end

endmodule

// ===== hw/rtl/cbp_dp.sv =====
// Datapath of the convolutional branch predictor: table row RAM, pending
// buffer RAM, shared MAC/training lane, histories and threshold logic.
// Depends on cbp_pkg and cbp_ram.
module cbp_dp #(
  parameter int HISTORY_LEN   = 32,
  parameter int WEIGHT_BITS   = 8,
  parameter int TABLE_ENTRIES = 2048,
  parameter int BUFFER_DEPTH  = 128
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  cbp_pkg::cmd_t                          cmd,
  output cbp_pkg::sts_t                          sts,
  input  logic                                   in_req_type,
  input  logic [cbp_pkg::ADDR_W-1:0]             in_branch_ip,
  input  logic [cbp_pkg::ADDR_W-1:0]             in_branch_target,
  input  logic                                   in_outcome_taken,
  input  logic                                   cfg_wr,
  input  logic [cbp_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [cbp_pkg::CFG_DATA_W-1:0]         cfg_data,
  output logic                                   out_valid,
  output logic                                   out_predicted_taken,
  output logic signed [cbp_pkg::OUT_W-1:0]       out_net_output,
  output logic                                   out_entry_found,
  output logic                                   out_trained
);

  localparam int NACT    = HISTORY_LEN - cbp_pkg::N_TAPS;
  localparam int WB      = WEIGHT_BITS;
  localparam int AW      = WEIGHT_BITS + 3;
  localparam int PW      = WB + AW;
  localparam int HL      = HISTORY_LEN;
  localparam int OW      = cbp_pkg::OUT_W;
  localparam int THW     = cbp_pkg::THR_W;
  localparam int IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int PTR_W   = $clog2(BUFFER_DEPTH);
  localparam int CNT_W   = $clog2(BUFFER_DEPTH + 1);
  localparam int STEP_W  = $clog2(NACT);
  localparam int LAYER_LO = cbp_pkg::N_TAPS * WB;
  localparam int ACT_LO   = LAYER_LO + NACT * WB;
  localparam int BIAS_LO  = ACT_LO + NACT * AW;
  localparam int ROW_W    = BIAS_LO + WB;
  localparam int PE_W     = cbp_pkg::ADDR_W + OW + HL + 1;
  localparam int PE_OUT_LO = HL + 1;
  localparam int PE_IP_LO  = PE_OUT_LO + OW;
  localparam int TW       = cbp_pkg::TC_W + 1;

  // Saturating one-step weight update
  function automatic logic signed [WB-1:0] sat_step(input logic signed [WB-1:0] w,
                                                    input logic up);
    logic signed [WB-1:0] wmax;
    logic signed [WB-1:0] wmin;
    wmax = {1'b0, {(WB-1){1'b1}}};
    wmin = {1'b1, {(WB-1){1'b0}}};
    if (up) begin
      sat_step = (w == wmax) ? w : w + WB'(1);
    end else begin
      sat_step = (w == wmin) ? w : w - WB'(1);
    end
  endfunction

  // Logical buffer slot to physical RAM address (circular, head = oldest)
  function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] head,
                                            input logic [CNT_W:0] k);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(head) + k;
    if (sum >= (CNT_W+1)'(BUFFER_DEPTH)) begin
      sum = sum - (CNT_W+1)'(BUFFER_DEPTH);
    end
    phys = sum[PTR_W-1:0];
  endfunction

  // Request and entry registers
  logic [cbp_pkg::ADDR_W-1:0]     ip_r;
  logic                           taken_r;
  logic [HL-1:0]                  hist_r;
  logic signed [OW-1:0]           o_r;
  logic                           p_r;
  logic [IDX_W-1:0]               last_off_r;
  logic [IDX_W-1:0]               idx_r;
  logic [HL-1:0]                  spec_r;
  logic [HL-1:0]                  real_r;
  logic [cbp_pkg::THR_W-1:0]      thr_r;
  logic signed [cbp_pkg::TC_W-1:0] tc_r;
  logic [cbp_pkg::THR_W-1:0]      init_thr_r;
  logic [cbp_pkg::SPD_W-1:0]      speed_r;
  logic [IDX_W-1:0]               clr_cnt_r;
  logic [STEP_W-1:0]              step_r;
  logic [CNT_W-1:0]               k_r;
  logic [CNT_W-1:0]               cnt_r;
  logic [PTR_W-1:0]               head_r;

  // Working row of one table entry
  logic signed [WB-1:0]           filt_r  [cbp_pkg::N_TAPS];
  logic signed [WB-1:0]           layer_r [NACT];
  logic signed [AW-1:0]           act_r   [NACT];
  logic signed [WB-1:0]           bias_r;
  logic [HL-1:0]                  hwin_r;
  logic signed [PW-1:0]           prod_r;
  logic signed [OW-1:0]           acc_r;

  logic                           out_valid_r;
  logic                           out_pred_r;
  logic signed [OW-1:0]           out_net_r;
  logic                           out_found_r;
  logic                           out_trained_r;

  // RAM ports
  logic                           tbl_we;
  logic [IDX_W-1:0]               tbl_waddr;
  logic [ROW_W-1:0]               tbl_wdata;
  logic [ROW_W-1:0]               tbl_rdata;
  logic [ROW_W-1:0]               row_pack;
  logic                           pnd_we;
  logic [PTR_W-1:0]               pnd_waddr;
  logic [PE_W-1:0]                pnd_wdata;
  logic [PTR_W-1:0]               pnd_raddr;
  logic [PE_W-1:0]                pnd_rdata;

  // Combinational helpers
  logic [31:0]                    h32;
  logic [cbp_pkg::ADDR_W-1:0]     h64;
  logic [IDX_W-1:0]               idx;
  logic [cbp_pkg::ADDR_W-1:0]     diff;
  logic signed [AW-1:0]           a_sum;
  logic signed [OW-1:0]           o_fin;
  logic                           p_fin;
  logic [CNT_W:0]                 rd_k;
  logic                           full;
  logic                           miss;
  logic signed [OW:0]             o_x;
  logic signed [OW:0]             t_x;
  logic signed [OW:0]             mag_x;
  logic                           low_conf;
  logic [HL-1:0]                  real_nxt;
  logic signed [TW-1:0]           spd_x;
  logic signed [TW-1:0]           tc_inc;
  logic signed [TW-1:0]           tc_dec;

  // Table index hash
  assign h32  = 32'(hist_r);
  assign h64  = ip_r ^ (ip_r >> HL) ^ {{32{h32[31]}}, h32};
  assign idx  = h64[IDX_W-1:0] + last_off_r;
  assign diff = in_branch_target - in_branch_ip;

  // One convolution output over the current 4-bit history window
  always_comb begin
    a_sum = '0;
    for (int j = 0; j < cbp_pkg::N_TAPS; j++) begin
      a_sum = a_sum + (hwin_r[j] ? AW'(filt_r[j]) : -AW'(filt_r[j]));
    end
  end

  assign o_fin = acc_r + OW'(prod_r) + OW'(bias_r);
  assign p_fin = !o_fin[OW-1];

  // Training decision and threshold compares
  assign miss  = (p_r != taken_r);
  assign o_x   = (OW+1)'(o_r);
  assign t_x   = $signed({{(OW+1-cbp_pkg::THR_W){1'b0}}, thr_r});
  assign mag_x = o_x[OW] ? -o_x : o_x;
  assign low_conf = (o_x <= t_x) && (o_x >= -t_x);
  assign real_nxt = {real_r[HL-2:0], taken_r};
  assign spd_x  = $signed({{(TW-cbp_pkg::SPD_W){1'b0}}, speed_r});
  assign tc_inc = TW'(tc_r) + TW'(1);
  assign tc_dec = TW'(tc_r) - TW'(1);

  // Status to the controller
  assign full          = (cnt_r == CNT_W'(BUFFER_DEPTH));
  assign sts.clr_last  = (clr_cnt_r == IDX_W'(TABLE_ENTRIES - 1));
  assign sts.step_last = (step_r == STEP_W'(NACT - 1));
  assign sts.k_end     = (k_r == cnt_r);
  assign sts.k_last    = ((CNT_W+1)'(k_r) + (CNT_W+1)'(1) == (CNT_W+1)'(cnt_r));
  assign sts.match     = (pnd_rdata[PE_IP_LO +: cbp_pkg::ADDR_W] == ip_r);
  assign sts.train     = low_conf || miss;

  // Pack the working row
  always_comb begin
    row_pack = '0;
    for (int j = 0; j < cbp_pkg::N_TAPS; j++) begin
      row_pack[j*WB +: WB] = filt_r[j];
    end
    for (int i = 0; i < NACT; i++) begin
      row_pack[LAYER_LO + i*WB +: WB] = layer_r[i];
      row_pack[ACT_LO + i*AW +: AW]   = act_r[i];
    end
    row_pack[BIAS_LO +: WB] = bias_r;
  end

  // Table RAM: cleared after reset, written back at the end of each pass
  assign tbl_we    = cmd.clr_step | cmd.p_fin | cmd.t_fin;
  assign tbl_waddr = cmd.clr_step ? clr_cnt_r : idx_r;
  assign tbl_wdata = cmd.clr_step ? '0 : row_pack;

  cbp_ram #(.WIDTH(ROW_W), .DEPTH(TABLE_ENTRIES)) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (idx),
    .rdata (tbl_rdata)
  );

  // Pending buffer RAM: push at the tail, compact by shifting one slot down
  assign rd_k      = cmd.sh_read ? (CNT_W+1)'(k_r) + (CNT_W+1)'(1) : (CNT_W+1)'(k_r);
  assign pnd_raddr = phys(head_r, rd_k);
  assign pnd_we    = cmd.p_fin | cmd.sh_write;
  assign pnd_waddr = cmd.p_fin ? phys(head_r, (CNT_W+1)'(cnt_r)) : phys(head_r, (CNT_W+1)'(k_r));
  assign pnd_wdata = cmd.p_fin ? {ip_r, o_fin, hist_r, p_fin} : pnd_rdata;

  cbp_ram #(.WIDTH(PE_W), .DEPTH(BUFFER_DEPTH)) u_pnd_ram (
    .clk   (clk),
    .we    (pnd_we),
    .waddr (pnd_waddr),
    .wdata (pnd_wdata),
    .raddr (pnd_raddr),
    .rdata (pnd_rdata)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_thr_r <= cbp_pkg::THR_RST;
      speed_r    <= cbp_pkg::SPD_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        cbp_pkg::REG_INIT_THR:    init_thr_r <= cfg_data;
        cbp_pkg::REG_ADAPT_SPEED: speed_r    <= cfg_data[cbp_pkg::SPD_W-1:0];
        default:                  init_thr_r <= init_thr_r;
      endcase
    end
  end

  // Control state: histories, buffer pointers, threshold, counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spec_r      <= '0;
      real_r      <= '0;
      last_off_r  <= '0;
      thr_r       <= cbp_pkg::THR_RST;
      tc_r        <= '0;
      clr_cnt_r   <= '0;
      k_r         <= '0;
      cnt_r       <= '0;
      head_r      <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.p_fin | cmd.r_none | (cmd.r_idx & !sts.train) | cmd.t_fin;

      // Clearing pass; the threshold takes its initial value when it ends
      if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + IDX_W'(1);
        if (sts.clr_last) begin
          thr_r <= init_thr_r;
        end
      end

      if (cmd.accept) begin
        k_r <= '0;
        if (in_req_type == cbp_pkg::REQ_PREDICT) begin
          last_off_r <= diff[IDX_W-1:0];
        end
      end

      if (cmd.p_load || cmd.t_load) begin
        step_r <= '0;
      end
      if (cmd.mac_step || cmd.t_step) begin
        step_r <= step_r + STEP_W'(1);
      end

      // Push the prediction, dropping the oldest when full
      if (cmd.p_fin) begin
        spec_r <= {spec_r[HL-2:0], p_fin};
        if (full) begin
          head_r <= (head_r == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
        end else begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end

      // Advance the search or the compaction
      if ((cmd.r_cmp && !sts.match) || cmd.sh_write) begin
        k_r <= k_r + CNT_W'(1);
      end

      // Retire the entry and update histories
      if (cmd.r_idx) begin
        cnt_r  <= cnt_r - CNT_W'(1);
        real_r <= real_nxt;
        if (miss) begin
          spec_r <= real_nxt;
        end
      end

      // Adapt the threshold after training
      if (cmd.t_fin) begin
        if (miss) begin
          if (tc_inc >= spd_x) begin
            if (thr_r < cbp_pkg::THR_MAX) begin
              thr_r <= thr_r + THW'(1);
            end
            tc_r <= '0;
          end else begin
            tc_r <= tc_inc[cbp_pkg::TC_W-1:0];
          end
        end else if (mag_x < t_x) begin
          if (tc_dec <= -spd_x) begin
            if (thr_r != '0) begin
              thr_r <= thr_r - THW'(1);
            end
            tc_r <= '0;
          end else begin
            tc_r <= tc_dec[cbp_pkg::TC_W-1:0];
          end
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ip_r    <= in_branch_ip;
      taken_r <= in_outcome_taken;
      hist_r  <= spec_r;
    end

    if (cmd.p_read || cmd.r_idx) begin
      idx_r <= idx;
    end

    // Latch the matched buffer entry
    if (cmd.r_cmp && sts.match) begin
      o_r    <= $signed(pnd_rdata[PE_OUT_LO +: OW]);
      hist_r <= pnd_rdata[1 +: HL];
      p_r    <= pnd_rdata[0];
    end

    // Load the table row
    if (cmd.p_load || cmd.t_load) begin
      for (int j = 0; j < cbp_pkg::N_TAPS; j++) begin
        filt_r[j] <= $signed(tbl_rdata[j*WB +: WB]);
      end
      for (int i = 0; i < NACT; i++) begin
        layer_r[i] <= $signed(tbl_rdata[LAYER_LO + i*WB +: WB]);
        act_r[i]   <= $signed(tbl_rdata[ACT_LO + i*AW +: AW]);
      end
    end
    if (cmd.p_load) begin
      bias_r <= $signed(tbl_rdata[BIAS_LO +: WB]);
      hwin_r <= hist_r;
      prod_r <= '0;
      acc_r  <= '0;
    end
    if (cmd.t_load) begin
      bias_r <= sat_step($signed(tbl_rdata[BIAS_LO +: WB]), taken_r);
      hwin_r <= taken_r ? hist_r : ~hist_r;
    end

    // One activation and one multiply-accumulate per cycle
    if (cmd.mac_step) begin
      prod_r <= PW'(layer_r[0]) * PW'(a_sum);
      acc_r  <= acc_r + OW'(prod_r);
      hwin_r <= hwin_r >> 1;
      for (int i = 0; i < NACT - 1; i++) begin
        layer_r[i] <= layer_r[i+1];
        act_r[i]   <= act_r[i+1];
      end
      layer_r[NACT-1] <= layer_r[0];
      act_r[NACT-1]   <= a_sum;
    end

    // One layer weight and all filter taps step per cycle
    if (cmd.t_step) begin
      hwin_r <= hwin_r >> 1;
      for (int i = 0; i < NACT - 1; i++) begin
        layer_r[i] <= layer_r[i+1];
        act_r[i]   <= act_r[i+1];
      end
      layer_r[NACT-1] <= sat_step(layer_r[0], taken_r == !act_r[0][AW-1]);
      act_r[NACT-1]   <= act_r[0];
      for (int j = 0; j < cbp_pkg::N_TAPS; j++) begin
        filt_r[j] <= sat_step(filt_r[j], hwin_r[j]);
      end
    end

    // Result fields
    if (cmd.p_fin) begin
      out_pred_r    <= p_fin;
      out_net_r     <= o_fin;
      out_found_r   <= 1'b0;
      out_trained_r <= 1'b0;
    end
    if (cmd.r_none || cmd.r_idx || cmd.t_fin) begin
      out_pred_r    <= 1'b0;
      out_net_r     <= '0;
      out_found_r   <= !cmd.r_none;
      out_trained_r <= cmd.t_fin;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_predicted_taken = out_pred_r;
  assign out_net_output      = out_net_r;
  assign out_entry_found     = out_found_r;
  assign out_trained         = out_trained_r;

endmodule

// ===== hw/rtl/conv_branch_predictor_top.sv =====
// Top level of the convolutional branch predictor: controller plus datapath.
// Depends on cbp_pkg, cbp_ctrl, cbp_dp and cbp_ram.
//
// Takes one request at a time: a transaction is accepted when start is high
// and busy is low, and its single result appears on the out_ ports for one
// cycle with out_valid, in the first idle cycle; the receiver cannot stall it.
// A predict keeps busy high while it reads and loads one table row, walks the
// HISTORY_LEN-4 activations of that row on the single multiply-accumulate lane,
// writes the row back and pushes the prediction into the pending buffer. A
// resolve keeps busy high while it searches the buffered entries up to the match
// (or to the end when nothing matches), shifts each younger entry down in the
// pending buffer RAM, retires the entry and, when the entry is trained, steps
// its table row (one layer weight and all filter taps per cycle). After reset a
// clearing pass zeroes all TABLE_ENTRIES rows of the table RAM while busy is
// high. Register writes are taken only while busy is low. TABLE_ENTRIES must be
// a power of two.
module conv_branch_predictor_top #(
  parameter int HISTORY_LEN   = 32,
  parameter int WEIGHT_BITS   = 8,
  parameter int TABLE_ENTRIES = 2048,
  parameter int BUFFER_DEPTH  = 128
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_req_type,
  input  logic [cbp_pkg::ADDR_W-1:0]         in_branch_ip,
  input  logic [cbp_pkg::ADDR_W-1:0]         in_branch_target,
  input  logic                               in_outcome_taken,
  output logic                               out_valid,
  output logic                               out_predicted_taken,
  output logic signed [cbp_pkg::OUT_W-1:0]   out_net_output,
  output logic                               out_entry_found,
  output logic                               out_trained,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cbp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cbp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  cbp_pkg::cmd_t cmd;
  cbp_pkg::sts_t sts;

  // Take register writes only while no transaction or clearing pass runs
  assign cfg_ready = !busy;

  cbp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_type (in_req_type),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  cbp_dp #(
    .HISTORY_LEN   (HISTORY_LEN),
    .WEIGHT_BITS   (WEIGHT_BITS),
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .BUFFER_DEPTH  (BUFFER_DEPTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_req_type         (in_req_type),
    .in_branch_ip        (in_branch_ip),
    .in_branch_target    (in_branch_target),
    .in_outcome_taken    (in_outcome_taken),
    .cfg_wr              (cfg_valid & cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .out_valid           (out_valid),
    .out_predicted_taken (out_predicted_taken),
    .out_net_output      (out_net_output),
    .out_entry_found     (out_entry_found),
    .out_trained         (out_trained)
  );

  // A result is only shown once the controller is back to idle
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // An accepted transaction always occupies the block
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not start work");

  // One result per transaction: never two strobes in a row
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back result strobes");

  // Compaction never runs past the end of the buffer
  a_shift_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sh_read |-> !sts.k_end)
    else $error("buffer shift beyond the fill count");

endmodule

// ===== bench/tb_conv_branch_predictor_top.sv =====
// Self-checking testbench for conv_branch_predictor_top: predict and resolve
// requests against a behavioral predictor with its own table and buffer state.
// Depends on cbp_pkg and the conv_branch_predictor_top RTL.
module tb_conv_branch_predictor_top;

  localparam int HIST_LEN   = 32;
  localparam int ROWS       = 2048;
  localparam int N_ACT      = HIST_LEN - 4;
  localparam int PEND_DEPTH = 128;
  localparam int W_MAX      = 127;
  localparam int W_MIN      = -128;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic                       req;
    logic [cbp_pkg::ADDR_W-1:0] ip;
    logic [cbp_pkg::ADDR_W-1:0] tgt;
    logic                       taken;
  } branch_req_t;

  typedef struct {
    logic                             pred_taken;
    logic signed [cbp_pkg::OUT_W-1:0] net;
    logic                             found;
    logic                             trained;
  } branch_res_t;

  typedef struct {
    logic [cbp_pkg::ADDR_W-1:0] ip;
    int                         net;
    logic [31:0]                hist;
    logic                       pred;
  } pend_entry_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_req_type = 1'b0;
  logic [cbp_pkg::ADDR_W-1:0] in_branch_ip = '0;
  logic [cbp_pkg::ADDR_W-1:0] in_branch_target = '0;
  logic in_outcome_taken = 1'b0;
  logic out_valid;
  logic out_predicted_taken;
  logic signed [cbp_pkg::OUT_W-1:0] out_net_output;
  logic out_entry_found;
  logic out_trained;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [cbp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [cbp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor state
  int filt_w [ROWS][4];
  int layer_w [ROWS][N_ACT];
  int act_val [ROWS][N_ACT];
  int bias_w [ROWS];
  logic [31:0] spec_hist;
  logic [31:0] real_hist;
  logic [10:0] last_off;
  int thr_val;
  int tune_cnt;
  int speed_reg;
  pend_entry_t pend_q[$];

  branch_res_t expected_q[$];
  int fail_cnt = 0;
  int stall_cnt = 0;
  bit quiet = 0;
  logic [cbp_pkg::ADDR_W-1:0] ip_pool [8];

  conv_branch_predictor_top i_dut (
    .clk, .rst_n, .start, .busy, .in_req_type, .in_branch_ip, .in_branch_target,
    .in_outcome_taken, .out_valid, .out_predicted_taken, .out_net_output,
    .out_entry_found, .out_trained, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int sat_step(int w, bit up);
    if (up) return (w < W_MAX) ? w + 1 : W_MAX;
    return (w > W_MIN) ? w - 1 : W_MIN;
  endfunction

  function automatic logic [10:0] row_of(logic [cbp_pkg::ADDR_W-1:0] ip, logic [31:0] hist);
    return (ip[10:0] ^ ip[42:32] ^ hist[10:0]) + last_off;
  endfunction

  // Evaluate a predict transaction and append it to the pending buffer
  function automatic branch_res_t model_predict(branch_req_t it);
    logic [31:0] d;
    logic [31:0] hist;
    logic [10:0] e;
    longint acc;
    int a;
    logic signed [cbp_pkg::OUT_W-1:0] o;
    branch_res_t r;
    pend_entry_t p;
    d = it.tgt[31:0] - it.ip[31:0];
    last_off = d[10:0];
    hist = spec_hist;
    e = row_of(it.ip, hist);
    acc = 0;
    for (int i = 0; i < N_ACT; i++) begin
      a = 0;
      for (int j = 0; j < 4; j++)
        a += hist[i+j] ? filt_w[e][j] : -filt_w[e][j];
      act_val[e][i] = a;
      acc += longint'(layer_w[e][i]) * a;
    end
    acc += bias_w[e];
    o = acc[cbp_pkg::OUT_W-1:0];
    r.net = o;
    r.pred_taken = (o >= 0);
    r.found = 1'b0;
    r.trained = 1'b0;
    if (pend_q.size() >= PEND_DEPTH) pend_q.delete(0);
    p.ip = it.ip;
    p.net = o;
    p.hist = hist;
    p.pred = r.pred_taken;
    pend_q.insert(pend_q.size(), p);
    spec_hist = {spec_hist[30:0], r.pred_taken};
    return r;
  endfunction

  // Retire the oldest pending prediction for the ip; train and adapt the threshold when needed
  function automatic branch_res_t resolve_branch(branch_req_t it);
    int k;
    pend_entry_t p;
    logic [10:0] e;
    logic [31:0] m;
    bit miss;
    int mag;
    branch_res_t r;
    r = '{1'b0, '0, 1'b0, 1'b0};
    k = 0;
    while (k < pend_q.size() && pend_q[k].ip != it.ip) k++;
    if (k >= pend_q.size()) return r;
    p = pend_q[k];
    pend_q.delete(k);
    e = row_of(it.ip, p.hist);
    real_hist = {real_hist[30:0], it.taken};
    miss = (p.pred != it.taken);
    if (miss) spec_hist = real_hist;
    r.found = 1'b1;
    if ((p.net <= thr_val && p.net >= -thr_val) || miss) begin
      r.trained = 1'b1;
      m = it.taken ? p.hist : ~p.hist;
      bias_w[e] = sat_step(bias_w[e], it.taken);
      for (int i = 0; i < N_ACT; i++)
        layer_w[e][i] = sat_step(layer_w[e][i], it.taken == (act_val[e][i] >= 0));
      for (int i = 0; i < N_ACT; i++)
        for (int j = 0; j < 4; j++)
          filt_w[e][j] = sat_step(filt_w[e][j], m[i+j]);
      mag = (p.net < 0) ? -p.net : p.net;
      if (miss) begin
        tune_cnt++;
        if (tune_cnt >= speed_reg) begin
          if (thr_val < 4095) thr_val++;
          tune_cnt = 0;
        end
      end else if (mag < thr_val) begin
        tune_cnt--;
        if (tune_cnt <= -speed_reg) begin
          if (thr_val > 0) thr_val--;
          tune_cnt = 0;
        end
      end
    end
    return r;
  endfunction

  // Send one transaction; start stays high afterwards unless an idle burst follows
  task automatic send_branch(logic req, logic [cbp_pkg::ADDR_W-1:0] ip,
                             logic [cbp_pkg::ADDR_W-1:0] tgt, logic taken);
    branch_req_t it;
    it = '{req, ip, tgt, taken};
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start <= 1'b1;
    in_req_type <= req;
    in_branch_ip <= ip;
    in_branch_target <= tgt;
    in_outcome_taken <= taken;
    do @(posedge clk); while (busy);
    if (req == cbp_pkg::REQ_PREDICT) expected_q.insert(expected_q.size(), model_predict(it));
    else expected_q.insert(expected_q.size(), resolve_branch(it));
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (busy || expected_q.size() != 0);
  endtask

  task automatic write_reg(logic [cbp_pkg::CFG_IDX_W-1:0] idx,
                           logic [cbp_pkg::CFG_DATA_W-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    // initial_threshold only reloads on reset, so the predictor ignores it
    if (idx == cbp_pkg::REG_ADAPT_SPEED) speed_reg = val[cbp_pkg::SPD_W-1:0];
  endtask

  function automatic logic [cbp_pkg::ADDR_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed();
    send_branch(cbp_pkg::REQ_PREDICT, '0, '0, 1'b0);
    send_branch(cbp_pkg::REQ_PREDICT, '1, '1, 1'b1);
    send_branch(cbp_pkg::REQ_PREDICT, 64'h0000_0001_0000_0000, 64'h0000_0000_8000_0000, 1'b0);
    send_branch(cbp_pkg::REQ_PREDICT, 64'h1234, 64'h1000, 1'b0);
    send_branch(cbp_pkg::REQ_RESOLVE, 64'h1234, '1, 1'b1);
    send_branch(cbp_pkg::REQ_RESOLVE, 64'hDEAD_BEEF, '0, 1'b0);
    send_branch(cbp_pkg::REQ_RESOLVE, '1, '0, 1'b0);
    send_branch(cbp_pkg::REQ_RESOLVE, '0, '0, 1'b1);
    send_branch(cbp_pkg::REQ_PREDICT, 64'h0000_0001_0000_0000, 64'h0000_0001_7FFF_FFFF, 1'b1);
    send_branch(cbp_pkg::REQ_PREDICT, 64'h0000_0001_0000_0000, '0, 1'b0);
    send_branch(cbp_pkg::REQ_RESOLVE, 64'h0000_0001_0000_0000, '0, 1'b1);
    send_branch(cbp_pkg::REQ_RESOLVE, 64'h0000_0001_0000_0000, '0, 1'b0);
    send_branch(cbp_pkg::REQ_RESOLVE, 64'h0000_0001_0000_0000, '0, 1'b1);
  endtask

  // Overfill the pending buffer so the oldest predictions drop out
  task automatic test_full_buffer();
    for (int i = 0; i < PEND_DEPTH + 4; i++)
      send_branch(cbp_pkg::REQ_PREDICT, 64'h5000 + i, rand64(), 1'b0);
    send_branch(cbp_pkg::REQ_RESOLVE, 64'h5000, '0, 1'b1);
    send_branch(cbp_pkg::REQ_RESOLVE, 64'h5003, '0, 1'b1);
    send_branch(cbp_pkg::REQ_RESOLVE, 64'h5004, '0, 1'b0);
    for (int i = 5; i < PEND_DEPTH + 4; i++)
      send_branch(cbp_pkg::REQ_RESOLVE, 64'h5000 + i, '0, 1'($urandom_range(0, 1)));
  endtask

  // Mostly predict/resolve pairs over a small ip pool, plus stray requests
  task automatic test_random_traffic(int n);
    logic [cbp_pkg::ADDR_W-1:0] ip;
    logic [cbp_pkg::ADDR_W-1:0] tgt;
    int sel;
    for (int i = 0; i < 8; i++) ip_pool[i] = rand64();
    for (int i = 0; i < n; i++) begin
      ip = ip_pool[$urandom_range(0, 7)];
      tgt = ($urandom_range(0, 1) == 0) ? ip + $urandom_range(0, 4096) - 2048 : rand64();
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        send_branch(cbp_pkg::REQ_PREDICT, ip, tgt, 1'($urandom_range(0, 1)));
        send_branch(cbp_pkg::REQ_RESOLVE, ip, rand64(), 1'($urandom_range(0, 1)));
        i++;
      end else if (sel < 85) begin
        send_branch(cbp_pkg::REQ_PREDICT, ip, tgt, 1'($urandom_range(0, 1)));
      end else if (sel < 95) begin
        send_branch(cbp_pkg::REQ_RESOLVE, ip, rand64(), 1'($urandom_range(0, 1)));
      end else begin
        send_branch(1'($urandom_range(0, 1)), rand64(), rand64(), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Check each result against the oldest expectation
  always @(posedge clk) begin : chk
    branch_res_t exp_r;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result: net_output %0d", out_net_output);
        fail_cnt++;
      end else begin
        exp_r = expected_q[0];
        expected_q.delete(0);
        if (out_predicted_taken !== exp_r.pred_taken) begin
          $error("predicted_taken exp %0b got %0b", exp_r.pred_taken, out_predicted_taken);
          fail_cnt++;
        end
        if (out_net_output !== exp_r.net) begin
          $error("net_output exp %0d got %0d", exp_r.net, out_net_output);
          fail_cnt++;
        end
        if (out_entry_found !== exp_r.found) begin
          $error("entry_found exp %0b got %0b", exp_r.found, out_entry_found);
          fail_cnt++;
        end
        if (out_trained !== exp_r.trained) begin
          $error("trained exp %0b got %0b", exp_r.trained, out_trained);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog: count cycles without an accepted transaction, a result or a register write
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    foreach (filt_w[i, j]) filt_w[i][j] = 0;
    foreach (layer_w[i, j]) begin
      layer_w[i][j] = 0;
      act_val[i][j] = 0;
    end
    foreach (bias_w[i]) bias_w[i] = 0;
    spec_hist = '0;
    real_hist = '0;
    last_off = '0;
    thr_val = cbp_pkg::THR_RST;
    tune_cnt = 0;
    speed_reg = cbp_pkg::SPD_RST;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_full_buffer();
    write_reg(cbp_pkg::REG_ADAPT_SPEED, 12'd1);
    write_reg(cbp_pkg::REG_INIT_THR, 12'd0);
    test_random_traffic(400);
    write_reg(cbp_pkg::REG_ADAPT_SPEED, 12'd31);
    write_reg(cbp_pkg::REG_INIT_THR, 12'd4095);
    test_random_traffic(400);
    write_reg(cbp_pkg::REG_ADAPT_SPEED, 12'($urandom_range(1, 31)));
    write_reg(cbp_pkg::REG_INIT_THR, 12'($urandom_range(0, 4095)));
    test_random_traffic(350);
    write_reg(cbp_pkg::REG_ADAPT_SPEED, 12'd2);
    quiet = 1;
    test_random_traffic(230);

    drain();
    repeat (100) @(posedge clk);
    if (fail_cnt == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
